/* rtl/pcbp_pkg.sv */
// Shared types and constants for the prefix code bit packer.
// No dependencies; the packer and the shifter refer to this package by scoped name.
package pcbp_pkg;

    localparam int BYTE_BITS    = 8;
    localparam int PEND_W       = 7;
    localparam int CNT_W        = 3;
    localparam int SYM_W        = 8;
    localparam int TABLE_DEPTH  = 256;
    localparam int MAX_BYTES    = 4;
    localparam int NB_W         = 3;
    localparam int SEARCH_DIGIT = 4;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_RSVD   = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } shf_ctl_t;

    typedef struct packed {
        logic srch;
        logic done;
        logic code_bit;
        logic tail_le8;
    } shf_stat_t;

endpackage

/* rtl/prefix_code_bit_packer.sv */
// Prefix code bit packer: 256-entry code table, bit-serial packing into bytes.
// Load writes a table entry. Encode reads the entry, loads the code shift register,
// searches for the sentinel (4 zero bits a cycle, then up to 3 single bits) and packs a
// code bit a cycle. Output stalls add cycles only when a finished byte is still waiting.
// Reset (synchronous, active low) clears table valid bits, pending bits and control.
// Depends on pcbp_pkg, pcbp_ram, pcbp_shifter.
module prefix_code_bit_packer #(
    parameter int CODE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_symbol,
    input  logic [31:0] s_code_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last
);

    localparam int NB_W = pcbp_pkg::NB_W;

    pcbp_pkg::state_t    state_reg, state_next;
    pcbp_pkg::shf_ctl_t  shf_ctl;
    pcbp_pkg::shf_stat_t shf_stat;

    logic [pcbp_pkg::TABLE_DEPTH-1:0] vld_reg, vld_next;
    logic                             rd_vld_reg, rd_vld_next;
    logic [pcbp_pkg::PEND_W-1:0]      pend_reg, pend_next;
    logic [pcbp_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [NB_W-1:0]                  nb_reg, nb_next;
    logic                             out_valid_reg, out_valid_next;
    logic [7:0]                       out_byte_reg, out_byte_next;
    logic                             out_last_reg, out_last_next;

    logic                  accept;
    logic                  do_load;
    logic                  do_encode;
    logic                  out_load;
    logic                  slot_free;
    logic                  full;
    logic                  emit;
    logic [CODE_WIDTH-1:0] rd_data;
    logic [CODE_WIDTH-1:0] load_code;
    logic [7:0]            flush_byte;

    assign s_ready   = state_reg == pcbp_pkg::ST_IDLE;
    assign accept    = s_valid && s_ready;
    assign do_load   = accept && s_opcode == pcbp_pkg::OP_LOAD;
    assign do_encode = accept && s_opcode == pcbp_pkg::OP_ENCODE;
    assign slot_free = !out_valid_reg || m_ready;
    assign full      = cnt_reg == pcbp_pkg::CNT_W'(pcbp_pkg::BYTE_BITS - 1);
    assign emit      = full && nb_reg < NB_W'(pcbp_pkg::MAX_BYTES);
    assign load_code = rd_vld_reg ? rd_data : '0;
    // left-align pending bits, zero pad
    assign flush_byte = 8'(({pend_reg, 8'd0}) >> cnt_reg);

    pcbp_ram #(
        .WIDTH (CODE_WIDTH),
        .DEPTH (pcbp_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (do_load),
        .waddr (s_symbol),
        .wdata (CODE_WIDTH'(s_code_word)),
        .re    (do_encode),
        .raddr (s_symbol),
        .rdata (rd_data)
    );

    pcbp_shifter #(
        .CODE_WIDTH (CODE_WIDTH)
    ) u_shifter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (shf_ctl),
        .load_code (load_code),
        .stat      (shf_stat)
    );

    always_comb begin
        state_next    = state_reg;
        vld_next      = vld_reg;
        rd_vld_next   = rd_vld_reg;
        pend_next     = pend_reg;
        cnt_next      = cnt_reg;
        nb_next       = nb_reg;
        out_load      = 1'b0;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        shf_ctl.load  = 1'b0;
        shf_ctl.step  = 1'b0;

        case (state_reg)
            pcbp_pkg::ST_IDLE: begin
                if (do_load) begin
                    vld_next[s_symbol] = 1'b1;
                end
                if (do_encode) begin
                    rd_vld_next = vld_reg[s_symbol];
                    state_next  = pcbp_pkg::ST_FETCH;
                end
                if (accept && s_opcode == pcbp_pkg::OP_FLUSH) begin
                    state_next = pcbp_pkg::ST_FLUSH;
                end
            end
            pcbp_pkg::ST_FETCH: begin
                shf_ctl.load = 1'b1;
                nb_next      = '0;
                state_next   = pcbp_pkg::ST_SHIFT;
            end
            pcbp_pkg::ST_SHIFT: begin
                if (!shf_stat.srch) begin
                    if (shf_stat.done) begin
                        state_next = pcbp_pkg::ST_IDLE;
                    end else if (!(emit && !slot_free)) begin
                        shf_ctl.step = 1'b1;
                        if (full) begin
                            pend_next = '0;
                            cnt_next  = '0;
                        end else begin
                            pend_next = {pend_reg[pcbp_pkg::PEND_W-2:0], shf_stat.code_bit};
                            cnt_next  = cnt_reg + pcbp_pkg::CNT_W'(1);
                        end
                        if (emit) begin
                            out_load      = 1'b1;
                            out_byte_next = {pend_reg, shf_stat.code_bit};
                            out_last_next = shf_stat.tail_le8 ||
                                            nb_reg == NB_W'(pcbp_pkg::MAX_BYTES - 1);
                            nb_next       = nb_reg + NB_W'(1);
                        end
                    end
                end
            end
            pcbp_pkg::ST_FLUSH: begin
                if (slot_free) begin
                    out_load      = 1'b1;
                    out_byte_next = flush_byte;
                    out_last_next = 1'b1;
                    pend_next     = '0;
                    cnt_next      = '0;
                    state_next    = pcbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pcbp_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pcbp_pkg::ST_IDLE;
            vld_reg       <= '0;
            pend_reg      <= '0;
            cnt_reg       <= '0;
            nb_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            vld_reg       <= vld_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            nb_reg        <= nb_next;
            out_valid_reg <= out_valid_next;
        end
        rd_vld_reg   <= rd_vld_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_last     = out_last_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_ready))
        else $error("output byte overwritten before it was taken");

    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pcbp_pkg::ST_FLUSH && out_load) |=> (m_last && cnt_reg == '0))
        else $error("flush byte not marked last or pending bits not cleared");

    a_byte_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        nb_reg <= NB_W'(pcbp_pkg::MAX_BYTES))
        else $error("more bytes emitted than an item allows");

    a_no_step_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        shf_ctl.step |-> (!shf_stat.srch && state_reg == pcbp_pkg::ST_SHIFT))
        else $error("code bit taken before the sentinel was found");

endmodule

/* rtl/pcbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/pcbp_shifter.sv */
// Code shift register: finds the sentinel one, then hands out code bits MSB first.
// Depends on pcbp_pkg.
module pcbp_shifter #(
    parameter int CODE_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pcbp_pkg::shf_ctl_t    ctl,
    input  logic [CODE_WIDTH-1:0] load_code,
    output pcbp_pkg::shf_stat_t   stat
);

    localparam int LW    = $clog2(CODE_WIDTH);
    localparam int CMP_W = LW + 4;
    localparam int DIG   = (CODE_WIDTH <= pcbp_pkg::SEARCH_DIGIT) ? 1 : pcbp_pkg::SEARCH_DIGIT;

    logic [CODE_WIDTH-1:0] sr_reg,   sr_next;
    logic [LW-1:0]         left_reg, left_next;
    logic                  srch_reg, srch_next;

    always_comb begin
        sr_next   = sr_reg;
        left_next = left_reg;
        srch_next = srch_reg;
        if (ctl.load) begin
            sr_next   = load_code;
            left_next = LW'(CODE_WIDTH - 1);
            srch_next = 1'b1;
        end else if (srch_reg) begin
            // left tracks how many bits sit below the sentinel once it reaches the top
            if (sr_reg[CODE_WIDTH-1] || left_reg == '0) begin
                srch_next = 1'b0;
            end else if (sr_reg[CODE_WIDTH-1 -: DIG] == '0 && left_reg >= LW'(DIG)) begin
                sr_next   = sr_reg << DIG;
                left_next = left_reg - LW'(DIG);
            end else begin
                sr_next   = sr_reg << 1;
                left_next = left_reg - LW'(1);
            end
        end else if (ctl.step) begin
            sr_next   = sr_reg << 1;
            left_next = left_reg - LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srch_reg <= 1'b0;
        end else begin
            srch_reg <= srch_next;
        end
        sr_reg   <= sr_next;
        left_reg <= left_next;
    end

    assign stat.srch     = srch_reg;
    assign stat.done     = !srch_reg && left_reg == '0;
    assign stat.code_bit = sr_reg[CODE_WIDTH-2];
    assign stat.tail_le8 = CMP_W'(left_reg) <= CMP_W'(pcbp_pkg::BYTE_BITS);

endmodule

/* test/tb_prefix_code_bit_packer.sv */
`timescale 1ns / 100ps
// Self-checking testbench for prefix_code_bit_packer: directed and random load/encode/flush
// items with random idling on both channels. Depends on pcbp_pkg and the packer RTL.
module tb_prefix_code_bit_packer;

    typedef struct {
        pcbp_pkg::opcode_t op;
        logic [7:0]        sym;
        logic [31:0]       word;
        bit                drain;
    } feed_t;

    typedef struct {
        logic [7:0] data;
        bit         last;
    } out_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode    = '0;
    logic [7:0]  s_symbol    = '0;
    logic [31:0] s_code_word = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last;

    feed_t feed_q[$];
    out_t  due_bytes[$];

    // Predictor state
    logic [31:0]                 tab_code [pcbp_pkg::TABLE_DEPTH] = '{default: '0};
    logic [pcbp_pkg::PEND_W-1:0] held_bits = '0;
    logic [pcbp_pkg::CNT_W-1:0]  held_cnt  = '0;

    int offered_cnt = 0;
    int taken_cnt   = 0;
    int bad_cnt     = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int hold_left   = 0;
    bit long_done   = 1'b0;

    prefix_code_bit_packer #(.CODE_WIDTH(32)) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_symbol    (s_symbol),
        .s_code_word (s_code_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last      (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Idle length for either side: mostly none or short, a few long; none in a calm window.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (taken_cnt >= 120 && taken_cnt < 150) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Work out the bytes one accepted item produces and update the packing state.
    task automatic pack_item(pcbp_pkg::opcode_t op, logic [7:0] sym, logic [31:0] word);
        logic [31:0] code;
        logic [7:0]  acc;
        int          len;
        int          cnt;
        int          nb;
        code = tab_code[sym];
        acc  = {1'b0, held_bits};
        cnt  = held_cnt;
        nb   = 0;
        len  = 0;
        case (op)
            pcbp_pkg::OP_LOAD: tab_code[sym] = word;
            pcbp_pkg::OP_ENCODE: begin
                // length is the position of the sentinel one
                for (int i = 1; i < 32; i++) if (code[i]) len = i;
                for (int b = len - 1; b >= 0; b--) begin
                    acc = {acc[6:0], code[b]};
                    cnt++;
                    if (cnt == pcbp_pkg::BYTE_BITS) begin
                        due_bytes.insert(due_bytes.size(), '{data: acc, last: 1'b0});
                        nb++;
                        acc = '0;
                        cnt = 0;
                    end
                end
                if (nb > 0) due_bytes[due_bytes.size() - 1].last = 1'b1;
                held_bits = acc[pcbp_pkg::PEND_W-1:0];
                held_cnt  = cnt[pcbp_pkg::CNT_W-1:0];
            end
            pcbp_pkg::OP_FLUSH: begin
                // left-align pending bits; an empty flush shifts everything out
                acc = acc << (pcbp_pkg::BYTE_BITS - cnt);
                due_bytes.insert(due_bytes.size(), '{data: acc, last: 1'b1});
                held_bits = '0;
                held_cnt  = '0;
            end
            default: ;
        endcase
    endtask

    task automatic add_item(pcbp_pkg::opcode_t op, logic [7:0] sym, logic [31:0] word,
                            bit drain);
        feed_q.insert(feed_q.size(), '{op: op, sym: sym, word: word, drain: drain});
    endtask

    // Input acceptance: predict at the edge that takes the item
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            pack_item(pcbp_pkg::opcode_t'(s_opcode), s_symbol, s_code_word);
            taken_cnt <= taken_cnt + 1;
        end
    end

    // Sender
    always @(negedge aclk) begin : drv
        bit    free;
        bit    go;
        feed_t nxt;
        free = !s_valid || (taken_cnt == offered_cnt);
        go   = 1'b0;
        if (aresetn && free) begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (feed_q.size() > 0 && !(feed_q[0].drain && due_bytes.size() > 0))
                go = 1'b1;
        end
        if (go) begin
            nxt = feed_q.pop_front();
            s_opcode    <= nxt.op;
            s_symbol    <= nxt.sym;
            s_code_word <= nxt.word;
            offered_cnt <= offered_cnt + 1;
            gap_left    <= idle_len();
        end
        if (free) s_valid <= go;
    end

    // Receiver: random stalls plus one long hold-off that backs the block up
    always @(negedge aclk) begin : rcv
        int n;
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_done && taken_cnt >= 70) begin
            m_ready   <= 1'b0;
            hold_left <= 300;
            long_done <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            n = idle_len();
            m_ready    <= (n == 0);
            stall_left <= (n > 0) ? n - 1 : 0;
        end
    end

    // Monitor
    always @(posedge aclk) begin : mon
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_bytes.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                         $time, m_out_byte, m_last);
                bad_cnt++;
            end else begin
                want = due_bytes.pop_front();
                if (m_out_byte !== want.data) begin
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, want.data, m_out_byte);
                    bad_cnt++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.last, m_last);
                    bad_cnt++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_prefix_code_bit_packer: FAIL");
        $finish;
    end

    initial begin
        int          total;
        int          len;
        int          r;
        logic [31:0] w;
        logic [7:0]  sy;
        logic [7:0]  loaded[$];

        // Directed: empty table, empty flush, sentinel extremes, reserved opcode
        add_item(pcbp_pkg::OP_ENCODE, 8'd0,   32'h0,         1'b0);
        add_item(pcbp_pkg::OP_FLUSH,  8'd0,   32'h0,         1'b0);
        add_item(pcbp_pkg::OP_LOAD,   8'd0,   32'h0,         1'b0);
        add_item(pcbp_pkg::OP_LOAD,   8'd1,   32'h1,         1'b0);
        add_item(pcbp_pkg::OP_LOAD,   8'd2,   32'h2,         1'b0);
        add_item(pcbp_pkg::OP_LOAD,   8'd3,   32'h3,         1'b0);
        add_item(pcbp_pkg::OP_LOAD,   8'd255, 32'hFFFF_FFFF, 1'b0);
        add_item(pcbp_pkg::OP_LOAD,   8'd128, 32'h8000_0000, 1'b0);
        add_item(pcbp_pkg::OP_LOAD,   8'd85,  32'h0000_015A, 1'b0);
        add_item(pcbp_pkg::OP_RSVD,   8'd3,   32'h5555_5555, 1'b0);
        add_item(pcbp_pkg::OP_ENCODE, 8'd0,   32'h0,         1'b0);
        add_item(pcbp_pkg::OP_ENCODE, 8'd1,   32'h0,         1'b0);
        add_item(pcbp_pkg::OP_ENCODE, 8'd3,   32'h0,         1'b0);
        add_item(pcbp_pkg::OP_FLUSH,  8'd0,   32'h0,         1'b0);
        add_item(pcbp_pkg::OP_ENCODE, 8'd85,  32'h0,         1'b0);
        add_item(pcbp_pkg::OP_ENCODE, 8'd255, 32'h0,         1'b0);
        add_item(pcbp_pkg::OP_ENCODE, 8'd255, 32'h0,         1'b0);
        add_item(pcbp_pkg::OP_ENCODE, 8'd128, 32'h0,         1'b0);
        add_item(pcbp_pkg::OP_ENCODE, 8'd2,   32'h0,         1'b0);
        add_item(pcbp_pkg::OP_RSVD,   8'd85,  32'hAAAA_AAAA, 1'b0);
        add_item(pcbp_pkg::OP_FLUSH,  8'hFF,  32'hFFFF_FFFF, 1'b0);
        add_item(pcbp_pkg::OP_LOAD,   8'd255, 32'h0,         1'b0);
        add_item(pcbp_pkg::OP_ENCODE, 8'd255, 32'h0,         1'b0);
        add_item(pcbp_pkg::OP_ENCODE, 8'd3,   32'h0,         1'b0);
        add_item(pcbp_pkg::OP_FLUSH,  8'd0,   32'h0,         1'b0);

        // Random: mostly encodes of loaded symbols, mixed with loads, flushes and reserved items
        for (int k = 0; k < 134; k++) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                sy = (loaded.size() > 0 && $urandom_range(0, 9) < 3) ?
                     loaded[$urandom_range(0, loaded.size() - 1)] : 8'($urandom);
                if ($urandom_range(0, 9) < 8) begin
                    len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12)
                                                      : $urandom_range(13, 31);
                    w = (32'h1 << len) | ($urandom & ((32'h1 << len) - 1));
                end else begin
                    w = $urandom;
                end
                loaded.insert(loaded.size(), sy);
                add_item(pcbp_pkg::OP_LOAD, sy, w, k == 0 || k == 90);
            end else if (r < 85) begin
                sy = (loaded.size() > 0 && $urandom_range(0, 9) < 9) ?
                     loaded[$urandom_range(0, loaded.size() - 1)] : 8'($urandom);
                add_item(pcbp_pkg::OP_ENCODE, sy, $urandom, k == 0 || k == 90);
            end else if (r < 95) begin
                add_item(pcbp_pkg::OP_FLUSH, 8'($urandom), $urandom, k == 0 || k == 90);
            end else begin
                add_item(pcbp_pkg::OP_RSVD, 8'($urandom), $urandom, k == 0 || k == 90);
            end
        end
        add_item(pcbp_pkg::OP_FLUSH, 8'd0, 32'h0, 1'b0);
        total = feed_q.size();

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        wait (taken_cnt == total);
        while (due_bytes.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        if (bad_cnt == 0)
            $display("tb_prefix_code_bit_packer: PASS");
        else
            $display("tb_prefix_code_bit_packer: FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/pcbp_pkg.sv
rtl/pcbp_ram.sv
rtl/pcbp_shifter.sv
rtl/prefix_code_bit_packer.sv
test/tb_prefix_code_bit_packer.sv
